FILE: rtl/core/rooted_tree_parent_table_core_defines.svh
// Assertion macros for the rooted tree parent table core.
// No dependencies; included by the top level only.
`ifndef ROOTED_TREE_PARENT_TABLE_CORE_DEFINES_SVH
`define ROOTED_TREE_PARENT_TABLE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define RTPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define RTPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define RTPT_ASSERT(lbl, prop, msg)
`define RTPT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/core/rtpt_pkg.sv
// Shared types and constants for the rooted tree parent table core.
// No dependencies.
package rtpt_pkg;
  localparam int CAPACITY = 64;
  localparam int KEY_BITS = 32;
  localparam int ID_BITS  = $clog2(CAPACITY);
  localparam int CNT_BITS = $clog2(CAPACITY + 1);

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_REPORT = 2'd2;
  localparam logic [1:0] CMD_NONE   = 2'd3;

  typedef logic signed [KEY_BITS-1:0] key_t;
  typedef logic [ID_BITS-1:0]         id_t;

  localparam key_t ROOT_KEY = key_t'(1);

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] node_key;
    logic signed [31:0] parent_key;
  } in_item_t;

  typedef struct packed {
    logic               failed;
    logic signed [31:0] found_parent_key;
  } out_item_t;

  typedef struct packed {
    logic live;
    key_t key;
    id_t  id;
    id_t  pid;
    key_t pkey;
  } cell_data_t;

  typedef struct packed {
    logic ins_en;
    logic del_en;
    key_t new_key;
    id_t  new_id;
    id_t  new_pid;
    key_t new_pkey;
    id_t  gone_id;
    id_t  up_id;
    key_t up_key;
  } cell_op_t;

  function automatic key_t key_from_input(logic signed [31:0] v);
    return key_t'(v);
  endfunction

  function automatic logic signed [31:0] key_to_output(key_t k);
    return 32'(k);
  endfunction
endpackage

FILE: rtl/core/rtpt_prio.sv
// Lowest-set-bit finder over one bit per table entry.
// Depends on rtpt_pkg.
module rtpt_prio (
  input  logic [rtpt_pkg::CAPACITY-1:0] req_i,
  output logic [rtpt_pkg::CAPACITY-1:0] oh_o,
  output rtpt_pkg::id_t                 idx_o,
  output logic                          any_o
);
  import rtpt_pkg::*;

  assign oh_o  = req_i & (~req_i + {{(CAPACITY-1){1'b0}}, 1'b1});
  assign any_o = |req_i;

  always_comb begin
    idx_o = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (oh_o[i]) idx_o = idx_o | id_t'(i);
    end
  end
endmodule

FILE: rtl/core/rtpt_cell.sv
// One table slot: key, id and parent fields, with compare, reparent and shift.
// Depends on rtpt_pkg.
module rtpt_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 root_i,
  input  rtpt_pkg::key_t       cmp_key_i,
  input  rtpt_pkg::cell_op_t   op_i,
  input  logic                 ins_sel_i,
  input  logic                 shift_sel_i,
  input  rtpt_pkg::cell_data_t nb_i,
  output rtpt_pkg::cell_data_t cur_o,
  output rtpt_pkg::cell_data_t nb_o,
  output logic                 match_o
);
  import rtpt_pkg::*;

  cell_data_t data_r;
  cell_data_t rep;

  // children of the removed node move up; root never does
  always_comb begin
    rep = data_r;
    if (!root_i && data_r.pid == op_i.gone_id) begin
      rep.pid  = op_i.up_id;
      rep.pkey = op_i.up_key;
    end
  end

  assign cur_o   = data_r;
  assign nb_o    = rep;
  assign match_o = data_r.live && (data_r.key == cmp_key_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r.live <= root_i;
      data_r.key  <= ROOT_KEY;
      data_r.id   <= '0;
    end else if (op_i.del_en) begin
      data_r <= shift_sel_i ? nb_i : rep;
    end else if (op_i.ins_en && ins_sel_i) begin
      data_r.live <= 1'b1;
      data_r.key  <= op_i.new_key;
      data_r.id   <= op_i.new_id;
      data_r.pid  <= op_i.new_pid;
      data_r.pkey <= op_i.new_pkey;
    end
  end
endmodule

FILE: rtl/core/rooted_tree_parent_table_core.sv
// Rooted tree parent table: top level, command sequencer and the row of cells.
// Depends on rtpt_pkg, rtpt_cell, rtpt_prio and the defines header.
//
// Use:
//   in_valid/in_stall carry one command per transfer (insert, delete, report).
//   out_valid/out_stall carry a result only for a failure or a report.
//   Successful inserts and deletes give no result; command 3 is dropped.
// Sequence:
//   An accepted command passes through three steps: accept, search, update.
//   The search compares every cell in parallel and registers the oldest match
//   and the lowest free id; the update then shifts or writes the cell row.
//   in_stall is high while a command is at work, so a new command is taken only
//   after the last has finished. A result appears on the cycle after update.
// Stall:
//   A result is held in the output register while out_stall is high; a
//   command that needs to report waits in the update step until it is free.
// Reset:
//   rst_n (synchronous, low) leaves only the root, key 1 and id 0, live.
`include "rooted_tree_parent_table_core_defines.svh"
module rooted_tree_parent_table_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rtpt_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rtpt_pkg::out_item_t out_data
);
  import rtpt_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_FIND, ST_EXEC} state_t;

  state_t               state_r;
  logic [1:0]           cmd_r;
  key_t                 nkey_r, pkey_r;
  logic [CNT_BITS-1:0]  live_count_r;
  logic [CAPACITY-1:0]  id_in_use_r;
  logic                 out_valid_r;
  out_item_t            out_data_r;

  // search results, registered in ST_FIND
  logic                 found_r;
  logic [CAPACITY-1:0]  sel_oh_r;
  cell_data_t           sel_r;
  id_t                  free_id_r;

  cell_data_t           cur [CAPACITY];
  cell_data_t           nb  [CAPACITY+1];
  logic [CAPACITY-1:0]  match_v, live_v, ins_oh, shift_v, sel_oh;
  logic                 found;
  id_t                  free_id;
  logic                 free_any;
  cell_data_t           sel_mux;
  key_t                 cmp_key;
  cell_op_t             op;
  logic                 fail, has_result, hold, go, full;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // insert compares the parent key, delete and report the node key
  assign cmp_key = (cmd_r == CMD_INSERT) ? pkey_r : nkey_r;
  assign nb[CAPACITY] = '0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    rtpt_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .root_i     (1'(g == 0)),
      .cmp_key_i  (cmp_key),
      .op_i       (op),
      .ins_sel_i  (ins_oh[g]),
      .shift_sel_i(shift_v[g]),
      .nb_i       (nb[g+1]),
      .cur_o      (cur[g]),
      .nb_o       (nb[g]),
      .match_o    (match_v[g])
    );
    assign live_v[g] = cur[g].live;
  end

  rtpt_prio u_match (
    .req_i(match_v), .oh_o(sel_oh), .idx_o(), .any_o(found)
  );

  rtpt_prio u_free (
    .req_i(~id_in_use_r), .oh_o(), .idx_o(free_id), .any_o(free_any)
  );

  // one-hot select of the oldest matching cell
  always_comb begin
    sel_mux = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (sel_oh[i]) sel_mux = sel_mux | cur[i];
    end
  end

  // first dead cell takes an insert; cells at and above the hit shift down
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ins_oh[i] = !live_v[i] && ((i == 0) || live_v[(i == 0) ? 0 : i-1]);
    end
  end
  assign shift_v = ~(sel_oh_r - {{(CAPACITY-1){1'b0}}, 1'b1});

  assign full = (live_count_r == CNT_BITS'(CAPACITY));

  always_comb begin
    unique case (cmd_r)
      CMD_INSERT: fail = !found_r || full;
      default:    fail = !found_r || sel_oh_r[0];
    endcase
  end

  assign has_result = fail || (cmd_r == CMD_REPORT);
  assign hold       = has_result && out_valid_r && out_stall;
  assign go         = (state_r == ST_EXEC) && !hold;

  always_comb begin
    op          = '0;
    op.ins_en   = go && !fail && (cmd_r == CMD_INSERT);
    op.del_en   = go && !fail && (cmd_r == CMD_DELETE);
    op.new_key  = nkey_r;
    op.new_id   = free_id_r;
    op.new_pid  = sel_r.id;
    op.new_pkey = sel_r.key;
    op.gone_id  = sel_r.id;
    op.up_id    = sel_r.pid;
    op.up_key   = sel_r.pkey;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      live_count_r <= CNT_BITS'(1);
      id_in_use_r  <= {{(CAPACITY-1){1'b0}}, 1'b1};
      out_valid_r  <= 1'b0;
    end else begin
      // a new result may load in the cycle the old one transfers
      if (go && has_result) out_valid_r <= 1'b1;
      else if (!out_stall)  out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            cmd_r  <= in_data.command;
            nkey_r <= key_from_input(in_data.node_key);
            pkey_r <= key_from_input(in_data.parent_key);
            if (in_data.command != CMD_NONE) state_r <= ST_FIND;
          end
        end
        ST_FIND: begin
          found_r   <= found;
          sel_oh_r  <= sel_oh;
          sel_r     <= sel_mux;
          free_id_r <= free_id;
          state_r   <= ST_EXEC;
        end
        ST_EXEC: begin
          if (go) begin
            if (has_result) begin
              out_data_r.failed           <= fail;
              out_data_r.found_parent_key <= fail ? 32'sd0 : key_to_output(sel_r.pkey);
            end
            if (op.ins_en && free_any) begin
              id_in_use_r[free_id_r] <= 1'b1;
              live_count_r           <= live_count_r + CNT_BITS'(1);
            end
            if (op.del_en) begin
              id_in_use_r[sel_r.id] <= 1'b0;
              live_count_r          <= live_count_r - CNT_BITS'(1);
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  `RTPT_ASSERT(a_live_range, live_count_r != 0 && live_count_r <= CNT_BITS'(CAPACITY), "live count out of range")
  `RTPT_ASSERT(a_live_match, $countones(live_v) == int'(live_count_r), "live cells disagree with count")
  `RTPT_ASSERT(a_root_kept, live_v[0] && id_in_use_r[0], "root lost")
  `RTPT_ASSERT_NEXT(a_exec_done, go, state_r == ST_IDLE, "update step did not finish")
endmodule

FILE: dv/tb_rooted_tree_parent_table_core.sv
// Self-checking testbench for the rooted tree parent table core.
// Depends on rtpt_pkg and rooted_tree_parent_table_core; holds its own tree predictor.
`timescale 1ns / 1ps
module tb_rooted_tree_parent_table_core;
  import rtpt_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  rooted_tree_parent_table_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #10 clk = ~clk;

  // Predicted tree: table of live nodes in insertion order
  key_t        tree_key  [CAPACITY];
  id_t         tree_id   [CAPACITY];
  id_t         tree_pid  [CAPACITY];
  key_t        tree_pkey [CAPACITY];
  int          tree_count;
  bit          id_taken  [CAPACITY];
  out_item_t   pending_results[$];
  int          error_count = 0;
  int          quiet_cycles = 0;
  bit          idle_in_on = 1'b1;   // random gaps on the input side
  bit          idle_out_on = 1'b1;  // random stalls on the result side

  function automatic void tree_clear();
    tree_count = 1;
    tree_key[0] = ROOT_KEY;
    tree_id[0] = '0;
    foreach (id_taken[i]) id_taken[i] = 1'b0;
    id_taken[0] = 1'b1;
  endfunction

  function automatic int oldest_match(key_t k);
    for (int i = 0; i < tree_count; i++)
      if (tree_key[i] == k) return i;
    return -1;
  endfunction

  // Applies one command to the predicted tree and queues any result
  function automatic void tree_apply(in_item_t it);
    int s;
    int nid;
    id_t gone;
    out_item_t fail_res;
    out_item_t rep;
    fail_res = '{failed: 1'b1, found_parent_key: '0};
    case (it.command)
      CMD_INSERT: begin
        s = oldest_match(key_t'(it.parent_key));
        if (s < 0 || tree_count >= CAPACITY) begin
          pending_results = {pending_results, fail_res};
          return;
        end
        nid = 0;
        while (nid < CAPACITY && id_taken[nid]) nid++;
        id_taken[nid] = 1'b1;
        tree_key[tree_count]  = key_t'(it.node_key);
        tree_id[tree_count]   = id_t'(nid);
        tree_pid[tree_count]  = tree_id[s];
        tree_pkey[tree_count] = tree_key[s];
        tree_count++;
      end
      CMD_DELETE: begin
        s = (tree_count <= 1) ? -1 : oldest_match(key_t'(it.node_key));
        if (s <= 0) begin
          pending_results = {pending_results, fail_res};
          return;
        end
        gone = tree_id[s];
        // orphans move up to the deleted node's parent
        for (int j = 1; j < tree_count; j++)
          if (tree_pid[j] == gone) begin
            tree_pid[j]  = tree_pid[s];
            tree_pkey[j] = tree_pkey[s];
          end
        id_taken[gone] = 1'b0;
        for (int j = s; j + 1 < tree_count; j++) begin
          tree_key[j]  = tree_key[j+1];
          tree_id[j]   = tree_id[j+1];
          tree_pid[j]  = tree_pid[j+1];
          tree_pkey[j] = tree_pkey[j+1];
        end
        tree_count--;
      end
      CMD_REPORT: begin
        s = (tree_count <= 1) ? -1 : oldest_match(key_t'(it.node_key));
        if (s <= 0) begin
          pending_results = {pending_results, fail_res};
          return;
        end
        rep.failed = 1'b0;
        rep.found_parent_key = 32'(tree_pkey[s]);
        pending_results = {pending_results, rep};
      end
      default: ;  // unused command: dropped
    endcase
  endfunction

  // Sends one command; predicts at the accepting edge.
  // Valid stays high after a transfer until the next command or a gap.
  task automatic send_command(input logic [1:0] cmd, input key_t nk, input key_t pk);
    if (idle_in_on) begin
      while ($urandom_range(99) < 25) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= '{command: cmd, node_key: nk, parent_key: pk};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tree_apply(in_data);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Result stall generation
  always @(posedge clk) begin
    if (idle_out_on) out_stall <= ($urandom_range(99) < 25);
    else out_stall <= 1'b0;
  end

  // Result checker, sampled at the edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result failed=%0b key=%0d", $time,
                 out_data.failed, out_data.found_parent_key);
        error_count++;
      end else begin
        out_item_t want;
        want = pending_results.pop_front();
        if (want.failed !== out_data.failed)
          $display("%0t: failed expected %0b actual %0b", $time, want.failed, out_data.failed);
        if (want.found_parent_key !== out_data.found_parent_key)
          $display("%0t: found_parent_key expected %0d actual %0d", $time,
                   want.found_parent_key, out_data.found_parent_key);
        if (want !== out_data) error_count++;
      end
    end
  end

  // Watchdog: cycles with no transfer on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_rooted_tree_parent_table_core: errors");
      $finish;
    end
  end

  // Root-only, root-targeted and unknown-key failures, command 3, reparenting, id reuse
  task automatic test_root_only();
    send_command(CMD_DELETE, ROOT_KEY, '0);
    send_command(CMD_REPORT, ROOT_KEY, '0);
    send_command(CMD_REPORT, key_t'(5), '0);
    send_command(CMD_INSERT, key_t'(7), key_t'(99));
    send_command(CMD_NONE, key_t'(1), key_t'(1));
    send_command(CMD_INSERT, key_t'(32'h7fffffff), ROOT_KEY);
    send_command(CMD_INSERT, key_t'(32'h80000000), key_t'(32'h7fffffff));
    send_command(CMD_INSERT, key_t'(-1), key_t'(32'h80000000));
    send_command(CMD_INSERT, key_t'(32'h7fffffff), ROOT_KEY); // duplicate key
    send_command(CMD_REPORT, key_t'(-1), '0);
    send_command(CMD_REPORT, key_t'(32'h80000000), '0);
    send_command(CMD_REPORT, key_t'(32'h7fffffff), '0);
    send_command(CMD_DELETE, ROOT_KEY, '0);               // root with children
    send_command(CMD_DELETE, key_t'(32'h80000000), '0);   // children move up
    send_command(CMD_REPORT, key_t'(-1), '0);
    send_command(CMD_DELETE, key_t'(12345), '0);
    send_command(CMD_INSERT, key_t'(0), key_t'(-1));      // reuses freed id
    send_command(CMD_REPORT, key_t'(0), '0);
    wait_drained();
  endtask

  // Fill to capacity with inserts running past it, then empty back to the root
  task automatic test_full_table();
    for (int i = 0; i < CAPACITY + 1; i++)
      send_command(CMD_INSERT, key_t'(1000 + i), ROOT_KEY);
    for (int i = 0; i < CAPACITY + 2; i++)
      send_command(CMD_DELETE, key_t'(tree_count > 1 ? tree_key[tree_count-1] : 7), '0);
    wait_drained();
  endtask

  // Random well-formed traffic over a small key space, some noise
  task automatic test_random_traffic(input int n);
    key_t nk, pk;
    int r;
    for (int i = 0; i < n; i++) begin
      idle_in_on = !(i >= n/3 && i < n/3 + 150);
      idle_out_on = idle_in_on;
      r = $urandom_range(99);
      pk = (tree_count > 0 && $urandom_range(9) < 8)
           ? tree_key[$urandom_range(tree_count-1)] : key_t'($urandom);
      nk = ($urandom_range(3) == 0) ? key_t'($urandom) : key_t'($urandom_range(40));
      if (r < 45)      send_command(CMD_INSERT, nk, pk);
      else if (r < 70) send_command(CMD_DELETE, (r < 65 ? pk : nk), key_t'($urandom));
      else if (r < 97) send_command(CMD_REPORT, (r < 92 ? pk : nk), key_t'($urandom));
      else             send_command(CMD_NONE, key_t'($urandom), key_t'($urandom));
    end
    idle_in_on = 1'b1;
    idle_out_on = 1'b1;
    wait_drained();
  endtask

  initial begin
    tree_clear();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_root_only();
    test_full_table();
    test_random_traffic(1350);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("tb_rooted_tree_parent_table_core: clean");
    end else begin
      $display("tb_rooted_tree_parent_table_core: errors");
    end
    $finish;
  end
endmodule

FILE: rooted_tree_parent_table_core.f
+incdir+rtl/core
rtl/core/rtpt_pkg.sv
rtl/core/rtpt_prio.sv
rtl/core/rtpt_cell.sv
rtl/core/rooted_tree_parent_table_core.sv
dv/tb_rooted_tree_parent_table_core.sv
